[sv/vector_distance_metric_unit_macros.svh]
// Assertion macros for the vector distance metric unit.
`ifndef VECTOR_DISTANCE_METRIC_UNIT_MACROS_SVH
`define VECTOR_DISTANCE_METRIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define VDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define VDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vdm_pkg.sv]
// Shared types and constants for the vector distance metric unit.
`timescale 1ns / 1ps

package vdm_pkg;

  localparam int ELEM_W = 32;
  localparam int DIST_W = 48;
  localparam int ACC_W  = 64;
  localparam int DEN_W  = 33;

  localparam logic [2:0] METRIC_NONE      = 3'd0;
  localparam logic [2:0] METRIC_EUCLID    = 3'd1;
  localparam logic [2:0] METRIC_MANHATTAN = 3'd2;
  localparam logic [2:0] METRIC_CHEBYSHEV = 3'd3;
  localparam logic [2:0] METRIC_CANBERRA  = 3'd4;
  localparam logic [2:0] METRIC_MINKOWSKI = 3'd5;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_element;
    logic signed [ELEM_W-1:0] b_element;
    logic                     last_pair;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } dist_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] result;
  } iter_rsp_t;

endpackage

[sv/vector_distance_metric_unit.sv]
// Top level of the vector distance metric unit: control, accumulator, output register.
//
//   channel   handshake                  payload
//   pair      pair_valid / pair_stall    pair_data   (pair_t)
//   dist      dist_valid / dist_stall    dist_data   (dist_t)
//   metric    metric_valid / metric_ready metric_data (3 bits)
//
// Each pair passes through the prep, load and accumulate states; euclidean and minkowski
// also wait in the iterate state for the bit-serial unit (32 multiply steps), as does
// canberra unless both elements are zero (17 divide steps). A last pair then ends in the
// done state, and under euclidean and minkowski it first runs the 32-step square root.
// rst is synchronous; it clears the metric, accumulator, overflow flag and dist_valid.
// A finished result waits in the output register under dist_stall; the next pair
// is taken meanwhile and only its own final transfer waits for the register.
`timescale 1ns / 1ps
`include "vector_distance_metric_unit_macros.svh"

module vector_distance_metric_unit
  import vdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pair_valid,
  output logic       pair_stall,
  input  pair_t      pair_data,
  output logic       dist_valid,
  input  logic       dist_stall,
  output dist_t      dist_data,
  input  logic       metric_valid,
  output logic       metric_ready,
  input  logic [2:0] metric_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PREP  = 8'b00000010,
    S_LOAD  = 8'b00000100,
    S_ITER  = 8'b00001000,
    S_ACC   = 8'b00010000,
    S_ROOT  = 8'b00100000,
    S_RWAIT = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [2:0]        metric;
  logic [2:0]        step_metric;
  logic [31:0]       a_q;
  logic [31:0]       b_q;
  logic              last_q;
  logic [31:0]       d_q;
  logic [31:0]       abs_a_q;
  logic [31:0]       abs_b_q;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  acc;
  logic              ovf;

  logic              pair_take;
  logic              out_free;
  logic [32:0]       diff_ab;
  logic [32:0]       diff_ba;
  logic [31:0]       d_next;
  logic [31:0]       abs_a_next;
  logic [31:0]       abs_b_next;
  logic [DEN_W-1:0]  den;
  logic              den_zero;
  logic              is_sq;
  logic              iter_needed;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  res;
  logic              clamp;
  iter_req_t         iter_req;
  iter_rsp_t         iter_rsp;
  logic [ACC_W-1:0]  opd_a;
  logic [DEN_W-1:0]  opd_b;

  assign metric_ready = 1'b1;
  assign pair_stall   = (state != S_IDLE);
  assign pair_take    = pair_valid && !pair_stall;
  assign out_free     = !dist_valid || !dist_stall;

  assign is_sq = (step_metric == METRIC_EUCLID) || (step_metric == METRIC_MINKOWSKI);

  always_comb begin
    diff_ab    = {a_q[31], a_q} - {b_q[31], b_q};
    diff_ba    = {b_q[31], b_q} - {a_q[31], a_q};
    d_next     = diff_ab[32] ? diff_ba[31:0] : diff_ab[31:0];
    abs_a_next = a_q[31] ? (32'd0 - a_q) : a_q;
    abs_b_next = b_q[31] ? (32'd0 - b_q) : b_q;
    den        = {1'b0, abs_a_q} + {1'b0, abs_b_q};
    den_zero   = (abs_a_q == 32'd0) && (abs_b_q == 32'd0);
    iter_needed = is_sq || ((step_metric == METRIC_CANBERRA) && !den_zero);
    sum        = {1'b0, acc} + {1'b0, term};
  end

  always_comb begin
    iter_req.start = ((state == S_LOAD) && iter_needed) || (state == S_ROOT);
    if (state == S_ROOT) begin
      iter_req.op = OP_SQRT;
    end else if (step_metric == METRIC_CANBERRA) begin
      iter_req.op = OP_DIV;
    end else begin
      iter_req.op = OP_MUL;
    end
    opd_a = (state == S_ROOT) ? acc : {32'd0, d_q};
    opd_b = (step_metric == METRIC_CANBERRA) ? den : {1'b0, d_q};
  end

  vdm_iter u_iter (
    .clk   (clk),
    .rst   (rst),
    .req   (iter_req),
    .opd_a (opd_a),
    .opd_b (opd_b),
    .rsp   (iter_rsp)
  );

  always_comb begin
    case (step_metric) inside
      METRIC_EUCLID, METRIC_MINKOWSKI:                    res = term;
      METRIC_MANHATTAN, METRIC_CHEBYSHEV, METRIC_CANBERRA: res = acc;
      default:                                            res = '0;
    endcase
    clamp = (res[ACC_W-1:DIST_W] != '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (pair_take) state_next = S_PREP;
      S_PREP:  state_next = S_LOAD;
      S_LOAD:  state_next = iter_needed ? S_ITER : S_ACC;
      S_ITER:  if (iter_rsp.done) state_next = S_ACC;
      S_ACC: begin
        if (!last_q) begin
          state_next = S_IDLE;
        end else if (is_sq) begin
          state_next = S_ROOT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ROOT:  state_next = S_RWAIT;
      S_RWAIT: if (iter_rsp.done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      metric      <= METRIC_NONE;
      step_metric <= METRIC_NONE;
      acc         <= '0;
      ovf         <= 1'b0;
      dist_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (metric_valid && metric_ready) begin
        metric <= metric_data;
      end
      if ((state == S_DONE) && out_free) begin
        dist_valid <= 1'b1;
      end else if (dist_valid && !dist_stall) begin
        dist_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pair_take) begin
            a_q         <= pair_data.a_element;
            b_q         <= pair_data.b_element;
            last_q      <= pair_data.last_pair;
            step_metric <= metric;
          end
        end
        S_PREP: begin
          d_q     <= d_next;
          abs_a_q <= abs_a_next;
          abs_b_q <= abs_b_next;
        end
        S_LOAD: begin
          if (!iter_needed) begin
            term <= (step_metric == METRIC_CANBERRA) ? '0 : {32'd0, d_q};
          end
        end
        S_ITER: begin
          if (iter_rsp.done) begin
            term <= iter_rsp.result;
          end
        end
        S_ACC: begin
          case (step_metric) inside
            METRIC_EUCLID, METRIC_MINKOWSKI, METRIC_MANHATTAN, METRIC_CANBERRA: begin
              if (sum[ACC_W]) begin
                acc <= '1;
                ovf <= 1'b1;
              end else begin
                acc <= sum[ACC_W-1:0];
              end
            end
            METRIC_CHEBYSHEV: begin
              if (term > acc) begin
                acc <= term;
              end
            end
            default: begin
              acc <= acc;
            end
          endcase
        end
        S_ROOT: begin
          term <= term;
        end
        S_RWAIT: begin
          if (iter_rsp.done) begin
            term <= iter_rsp.result;
          end
        end
        S_DONE: begin
          if (out_free) begin
            dist_data.distance  <= clamp ? '1 : res[DIST_W-1:0];
            dist_data.saturated <= ovf || clamp;
            acc                 <= '0;
            ovf                 <= 1'b0;
          end
        end
        default: begin
          term <= term;
        end
      endcase
    end
  end

  `VDM_ASSERT_NOW(a_ovf_pins_acc, ovf, (acc == '1), "overflow flag set without a saturated accumulator")
  `VDM_ASSERT_NOW(a_iter_done_waited, iter_rsp.done, ((state == S_ITER) || (state == S_RWAIT)), "serial unit finished outside a wait state")
  `VDM_ASSERT_NEXT(a_clear_after_result, ((state == S_DONE) && out_free), ((acc == '0) && !ovf && dist_valid), "accumulator not cleared after result transfer")

endmodule

[sv/vdm_iter.sv]
// Bit-serial multiply, divide and square root unit sharing one shift datapath.
`timescale 1ns / 1ps

module vdm_iter
  import vdm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  iter_req_t        req,
  input  logic [ACC_W-1:0] opd_a,
  input  logic [DEN_W-1:0] opd_b,
  output iter_rsp_t        rsp
);

  localparam logic [5:0] MUL_STEPS  = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd17;
  localparam logic [5:0] SQRT_STEPS = 6'd32;

  logic        busy;
  logic        done;
  iter_op_t    op_q;
  logic [5:0]  cnt;
  logic [34:0] hi;
  logic [63:0] lo;
  logic [32:0] dv;

  logic [32:0] mul_sum;
  logic [34:0] sub_a;
  logic [34:0] sub_b;
  logic [35:0] sub_d;
  logic        take;
  logic [34:0] sub_r;
  logic [63:0] result;

  always_comb begin
    mul_sum = {1'b0, hi[31:0]} + (lo[0] ? {1'b0, dv[31:0]} : 33'd0);
    if (op_q == OP_SQRT) begin
      sub_a = {hi[32:0], lo[63:62]};
      sub_b = {1'b0, dv[31:0], 2'b01};
    end else begin
      sub_a = {hi[33:0], lo[63]};
      sub_b = {2'b00, dv};
    end
    sub_d = {1'b0, sub_a} - {1'b0, sub_b};
    take  = ~sub_d[35];
    sub_r = take ? sub_d[34:0] : sub_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_q <= OP_MUL;
    end else begin
      done <= busy && (cnt == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        op_q <= req.op;
        unique case (req.op)
          OP_MUL: begin
            hi  <= '0;
            lo  <= {32'd0, opd_a[31:0]};
            dv  <= opd_b;
            cnt <= MUL_STEPS - 6'd1;
          end
          OP_DIV: begin
            hi  <= {4'd0, opd_a[31:1]};
            lo  <= {opd_a[0], 63'd0};
            dv  <= opd_b;
            cnt <= DIV_STEPS - 6'd1;
          end
          OP_SQRT: begin
            hi  <= '0;
            lo  <= opd_a;
            dv  <= '0;
            cnt <= SQRT_STEPS - 6'd1;
          end
          default: begin
            hi  <= '0;
            lo  <= '0;
            dv  <= '0;
            cnt <= 6'd0;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
        unique case (op_q)
          OP_MUL: begin
            hi <= {3'd0, mul_sum[32:1]};
            lo <= {lo[63:32], mul_sum[0], lo[31:1]};
          end
          OP_DIV: begin
            hi <= sub_r;
            lo <= {lo[62:0], take};
          end
          OP_SQRT: begin
            hi <= sub_r;
            lo <= {lo[61:0], 2'b00};
            dv <= {dv[31:0], take};
          end
          default: begin
            hi <= hi;
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (op_q)
      OP_MUL:  result = {hi[31:0], lo[31:0]};
      OP_DIV:  result = {47'd0, lo[16:0]};
      OP_SQRT: result = {32'd0, dv[31:0]};
      default: result = '0;
    endcase
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

[bench/vector_distance_metric_unit_test.sv]
// Self-checking bench for the vector distance metric unit: predicted distances against the DUT.
`timescale 1ns / 1ps

module vector_distance_metric_unit_test
  import vdm_pkg::*;
();

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int IDLE_WAIT   = 150;
  localparam int RANDOM_PAIRS = 550;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  class distance_scoreboard;
    logic [2:0]  metric_code;
    bit   [63:0] acc_sum;
    bit          overflow_flag;
    dist_t       expected_distances[$];
    int          errors;

    function new();
      metric_code   = METRIC_NONE;
      acc_sum       = '0;
      overflow_flag = 1'b0;
      errors        = 0;
    endfunction

    function void set_metric(logic [2:0] code);
      metric_code = code;
    endfunction

    function int pending();
      return expected_distances.size();
    endfunction

    function void add_saturating(bit [63:0] term);
      bit [64:0] wide;
      wide = {1'b0, acc_sum} + {1'b0, term};
      if (wide[64]) begin
        acc_sum       = '1;
        overflow_flag = 1'b1;
      end else begin
        acc_sum = wide[63:0];
      end
    endfunction

    function bit [63:0] root_floor(bit [63:0] v);
      bit [31:0] r;
      bit [31:0] c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        c = r | (32'd1 << i);
        if ({32'd0, c} * {32'd0, c} <= v) r = c;
      end
      return {32'd0, r};
    endfunction

    function void note_pair(pair_t p);
      longint    a;
      longint    b;
      longint    diff;
      bit [63:0] d;
      bit [63:0] den;
      bit [63:0] res;
      bit        sat;
      dist_t     want;
      a    = longint'($signed(p.a_element));
      b    = longint'($signed(p.b_element));
      diff = a - b;
      d    = (diff < 0) ? -diff : diff;
      den  = ((a < 0) ? -a : a) + ((b < 0) ? -b : b);
      case (metric_code) inside
        METRIC_EUCLID, METRIC_MINKOWSKI: add_saturating(d * d);
        METRIC_MANHATTAN: add_saturating(d);
        METRIC_CHEBYSHEV: if (d > acc_sum) acc_sum = d;
        METRIC_CANBERRA: if (den != 0) add_saturating((d << 16) / den);
        default: ;
      endcase
      if (!p.last_pair) return;
      sat = overflow_flag;
      case (metric_code) inside
        METRIC_EUCLID, METRIC_MINKOWSKI: res = root_floor(acc_sum);
        METRIC_MANHATTAN, METRIC_CHEBYSHEV, METRIC_CANBERRA: res = acc_sum;
        default: res = '0;
      endcase
      if (res > 64'h0000_FFFF_FFFF_FFFF) begin
        res = 64'h0000_FFFF_FFFF_FFFF;
        sat = 1'b1;
      end
      want.distance  = res[DIST_W-1:0];
      want.saturated = sat;
      expected_distances.push_back(want);
      acc_sum       = '0;
      overflow_flag = 1'b0;
    endfunction

    function void check_distance(dist_t got);
      dist_t want;
      if (expected_distances.size() == 0) begin
        $display("%0t: distance transfer with none expected, actual %h sat %b",
                 $time, got.distance, got.saturated);
        errors++;
        return;
      end
      want = expected_distances.pop_front();
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %h actual %h", $time, want.distance, got.distance);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       pair_valid;
  logic       pair_stall;
  pair_t      pair_data;
  logic       dist_valid;
  logic       dist_stall;
  dist_t      dist_data;
  logic       metric_valid;
  logic       metric_ready;
  logic [2:0] metric_data;

  distance_scoreboard sb;
  int burst_left;
  int cycle_count;
  int random_pairs;

  vector_distance_metric_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair_data    (pair_data),
    .dist_valid   (dist_valid),
    .dist_stall   (dist_stall),
    .dist_data    (dist_data),
    .metric_valid (metric_valid),
    .metric_ready (metric_ready),
    .metric_data  (metric_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && dist_valid && !dist_stall) sb.check_distance(dist_data);
  end

  // Receiver: random stall modes, plus a long periodic hold.
  initial begin
    int rx_cycle;
    int mode;
    int span;
    dist_stall = 1'b0;
    rx_cycle   = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        rx_cycle++;
        if (rx_cycle % 3000 >= 2600) dist_stall <= 1'b1;
        else begin
          case (mode)
            0: dist_stall <= 1'b0;
            1: dist_stall <= 1'($urandom_range(0, 1));
            2: dist_stall <= ($urandom_range(0, 3) != 0);
            default: dist_stall <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pair(pair_t p, bit nogap);
    int gap;
    if (!nogap && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pair_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    pair_valid <= 1'b1;
    pair_data  <= p;
    do @(posedge clk); while (pair_stall);
    @(negedge clk);
    sb.note_pair(p);
  endtask

  task automatic put(logic [31:0] a, logic [31:0] b, bit last);
    pair_t p;
    p.a_element = a;
    p.b_element = b;
    p.last_pair = last;
    send_pair(p, 1'b0);
  endtask

  // Drain, let the block go quiet, then write the metric register.
  task automatic switch_metric(logic [2:0] code);
    pair_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    metric_valid <= 1'b1;
    metric_data  <= code;
    do @(posedge clk); while (!metric_ready);
    sb.set_metric(code);
    @(negedge clk);
    metric_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_element();
    logic [31:0] small_val;
    small_val = $urandom_range(0, 32'h0003_FFFF);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return ($urandom_range(0, 1) != 0) ? -small_val : small_val;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int          phase;
    int          vectors;
    int          len;
    bit          broken;
    sb           = new();
    rst          = 1'b1;
    pair_valid   = 1'b0;
    pair_data    = '0;
    metric_valid = 1'b0;
    metric_data  = '0;
    burst_left   = 0;
    random_pairs = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    put(32'h0000_0005, 32'h0000_0003, 1'b1);

    switch_metric(METRIC_EUCLID);
    put(Q_MAX, Q_MIN, 1'b0);
    put(Q_MAX, Q_MIN, 1'b1);
    put(32'h0003_0000, 32'h0, 1'b1);

    switch_metric(METRIC_MANHATTAN);
    put(32'hFFFE_8000, 32'h0002_4000, 1'b0);
    put(Q_MIN, Q_MAX, 1'b1);

    switch_metric(METRIC_CHEBYSHEV);
    put(32'h0000_0001, 32'h0000_0005, 1'b0);
    put(Q_MIN, Q_MAX, 1'b0);
    put(32'h0, 32'h0, 1'b1);

    switch_metric(METRIC_CANBERRA);
    put(32'h0, 32'h0, 1'b1);
    put(32'h0001_0000, 32'hFFFF_0000, 1'b0);
    put(32'h0, 32'h0, 1'b0);
    put(Q_MIN, 32'h0, 1'b1);

    switch_metric(METRIC_MINKOWSKI);
    put(32'h0003_0000, 32'hFFFF_0000, 1'b0);
    put(Q_MIN, Q_MIN, 1'b1);

    switch_metric(3'd6);
    put(32'h0000_0001, 32'h0000_0002, 1'b1);
    switch_metric(3'd7);
    put(32'h0000_0001, 32'h0000_0002, 1'b1);

    // Metric changes in the middle of a vector.
    switch_metric(METRIC_MANHATTAN);
    put(32'h0000_000A, 32'h0, 1'b0);
    switch_metric(METRIC_CHEBYSHEV);
    put(32'h0000_0005, 32'h0, 1'b1);
    switch_metric(METRIC_EUCLID);
    put(Q_MAX, Q_MIN, 1'b0);
    put(Q_MAX, Q_MIN, 1'b0);
    switch_metric(METRIC_NONE);
    put(32'h0000_0001, 32'h0000_0002, 1'b1);

    phase = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      switch_metric((phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7)));
      phase++;
      vectors = $urandom_range(2, 8);
      for (int v = 0; v < vectors; v++) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        broken = (v == vectors - 1) && ($urandom_range(0, 5) == 0);
        for (int k = 0; k < len; k++) begin
          a = rand_element();
          case ($urandom_range(0, 7))
            0: b = a;
            1: b = -a;
            default: b = rand_element();
          endcase
          if ($urandom_range(0, 15) == 0) put(a, b, 1'($urandom_range(0, 1)));
          else put(a, b, (k == len - 1) && !broken);
          random_pairs++;
        end
      end
    end

    pair_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/vdm_pkg.sv
sv/vdm_iter.sv
sv/vector_distance_metric_unit.sv
bench/vector_distance_metric_unit_test.sv
